@@ rtl/srf_pkg.sv @@
// ----------------------------------------------------------------------------
// srf_pkg
// Shared types and constants for the overwrite-oldest sample ring FIFO.
// ----------------------------------------------------------------------------
package srf_pkg;

  localparam int unsigned DEF_CAPACITY = 4096;
  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned FILL_W       = 13;
  localparam int unsigned FUNC_W       = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } srf_op_e;

  typedef struct packed {
    logic              pop_ok;
    logic              underrun;
    logic              dropped;
    logic [FILL_W-1:0] fill;
  } srf_flags_t;

endpackage

@@ rtl/srf_ram.sv @@
// ----------------------------------------------------------------------------
// srf_ram
// Single-port-write, single-port-read sample memory, registered read data.
// ----------------------------------------------------------------------------
module srf_ram
  import srf_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  localparam int unsigned PTR_W   = $clog2(CAPACITY)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [PTR_W-1:0]    waddr_i,
  input  logic [SAMPLE_W-1:0] wdata_i,
  input  logic                re_i,
  input  logic [PTR_W-1:0]    raddr_i,
  output logic [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem [CAPACITY];
  logic [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sample_ring_fifo_overwrite.sv @@
// ----------------------------------------------------------------------------
// sample_ring_fifo_overwrite
// Circular sample FIFO; a push into a full store discards the oldest sample.
//
//   channel | valid       | stall        | payload
//   in      | in_valid_i  | in_stall_o   | func_i, in_sample_i
//   out     | out_valid_o | out_stall_i  | out_sample_o, underrun_o,
//           |             |              | dropped_oldest_o, fill_level_o
//
// One beat per cycle sustained while the output is not stalled; a beat
// passes the read stage, then the output register. Pointers and occupancy
// update at accept; a pop reads memory, its data ready in the read stage.
// Reset clears pointers and occupancy; memory contents are not cleared.
// A stalled output holds the read stage, which then stalls the input.
// ----------------------------------------------------------------------------
module sample_ring_fifo_overwrite
  import srf_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [SAMPLE_W-1:0] in_sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SAMPLE_W-1:0] out_sample_o,
  output logic                underrun_o,
  output logic                dropped_oldest_o,
  output logic [FILL_W-1:0]   fill_level_o
);

  localparam int unsigned PTR_W = $clog2(CAPACITY);
  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);

  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d, rd_ptr_inc;
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d, wr_ptr_inc;
  logic [OCC_W-1:0]    occ_q, occ_d;
  logic                accept;
  logic                mem_we, mem_re;
  logic [SAMPLE_W-1:0] mem_rdata;
  srf_flags_t          flags_d;

  logic                rs_valid_q;
  srf_flags_t          rs_flags_q;
  logic                rs_move;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  srf_flags_t          out_flags_q;

  assign rs_move    = rs_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = rs_valid_q && !rs_move;
  assign accept     = in_valid_i && !in_stall_o;

  assign rd_ptr_inc = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
  assign wr_ptr_inc = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    occ_d    = occ_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    flags_d  = '0;
    unique case (func_i)
      OP_PUSH: begin
        mem_we   = accept;
        wr_ptr_d = wr_ptr_inc;
        if (occ_q == OCC_FULL) begin
          rd_ptr_d        = rd_ptr_inc;
          flags_d.dropped = 1'b1;
        end else begin
          occ_d = occ_q + OCC_W'(1);
        end
      end
      OP_POP: begin
        if (occ_q == '0) begin
          flags_d.underrun = 1'b1;
        end else begin
          mem_re         = accept;
          flags_d.pop_ok = 1'b1;
          rd_ptr_d       = rd_ptr_inc;
          occ_d          = occ_q - OCC_W'(1);
        end
      end
      OP_CLEAR: begin
        rd_ptr_d = '0;
        wr_ptr_d = '0;
        occ_d    = '0;
      end
      default: begin
      end
    endcase
    flags_d.fill = FILL_W'(occ_d);
  end

  srf_ram #(
    .CAPACITY (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (in_sample_i),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      occ_q    <= '0;
    end else if (accept) begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      occ_q    <= occ_d;
    end
  end

  // read stage: flags wait here for the memory data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_valid_q <= 1'b0;
    end else if (accept) begin
      rs_valid_q <= 1'b1;
    end else if (rs_move) begin
      rs_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rs_flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rs_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rs_move) begin
      out_flags_q  <= rs_flags_q;
      out_sample_q <= rs_flags_q.pop_ok ? mem_rdata : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_sample_o     = out_sample_q;
  assign underrun_o       = out_flags_q.underrun;
  assign dropped_oldest_o = out_flags_q.dropped;
  assign fill_level_o     = out_flags_q.fill;

endmodule
